/* hw/rtl/segment_box_hit_test_macros.svh */
// ----------------------------------------------------------------------------
// Segment box hit test: assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_HIT_TEST_MACROS_SVH
`define SEGMENT_BOX_HIT_TEST_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SBH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SBH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sbh_pkg.sv */
// ----------------------------------------------------------------------------
// Segment box hit test package
// Register indexes and the words passed between pipeline stages.
// ----------------------------------------------------------------------------
package sbh_pkg;

   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_idx_type;

   // Output of the front stages: offsets, direction, face crossing terms.
   typedef struct packed {
      logic [2:0][32:0]      p;
      logic [2:0][31:0]      d;
      logic [2:0][30:0]      h;
      logic [2:0][31:0]      ad;
      logic [2:0][1:0][34:0] ns;
      logic [2:0][1:0]       ok;
      logic                  in_box;
   } front_type;

   // Output of the product stage.
   typedef struct packed {
      logic [2:0][1:0][65:0]      pa;
      logic [2:0][1:0][1:0][66:0] dn;
      logic [2:0][1:0][62:0]      ha;
      logic [2:0][1:0]            ok;
      logic                       in_box;
   } prod_type;

endpackage

/* hw/rtl/sbh_front.sv */
// ----------------------------------------------------------------------------
// Segment box hit test: front stages
// Stage 1 forms box-relative end points; stage 2 the face crossing terms.
// ----------------------------------------------------------------------------
module sbh_front #(
   parameter int COORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [2:0][31:0]         origin,
   input  logic [2:0][31:0]         dir,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  logic [2:0][31:0]         center,
   input  logic [2:0][30:0]         half,
   output logic                     out_valid,
   input  logic                     out_stall,
   output sbh_pkg::front_type       out_word
);
   import sbh_pkg::*;

   localparam int SIG = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int MAG = (COORD_BITS - 1 < 31) ? COORD_BITS - 1 : 31;
   localparam int SH  = 32 - SIG;
   localparam logic [30:0] H_MASK = (31'(1) << MAG) - 31'(1);

   function automatic logic [31:0] fit(input logic [31:0] v);
      logic signed [31:0] s;
      s = signed'(v << SH);
      return 32'(s >>> SH);
   endfunction

   logic                  s1_valid_ff;
   logic [2:0][32:0]      s1_p_ff, s1_p_in;
   logic [2:0][33:0]      s1_t_ff, s1_t_in;
   logic [2:0][30:0]      s1_h_ff, s1_h_in;
   logic [2:0][31:0]      s1_d_ff, s1_d_in;
   logic                  s2_valid_ff;
   front_type             s2_ff, s2_in;
   logic                  s1_ready, s2_ready;

   assign s2_ready  = !s2_valid_ff || !out_stall;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_stall  = !s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_word  = s2_ff;

   always_comb begin
      logic [31:0] o, c;
      for (int i = 0; i < 3; i++) begin
         o = fit(origin[i]);
         c = fit(center[i]);
         s1_d_in[i] = fit(dir[i]);
         s1_h_in[i] = half[i] & H_MASK;
         s1_p_in[i] = {o[31], o} - {c[31], c};
         s1_t_in[i] = {s1_p_in[i][32], s1_p_in[i]} + {{2{s1_d_in[i][31]}}, s1_d_in[i]};
      end
   end

   always_comb begin
      logic [34:0] hf, face, n, absn;
      logic [32:0] absp;
      logic [33:0] abst;
      logic        in_p, in_t, dpos, dnz;
      in_p = 1'b1;
      in_t = 1'b1;
      s2_in.p = s1_p_ff;
      s2_in.d = s1_d_ff;
      s2_in.h = s1_h_ff;
      for (int a = 0; a < 3; a++) begin
         absp = s1_p_ff[a][32] ? 33'd0 - s1_p_ff[a] : s1_p_ff[a];
         abst = s1_t_ff[a][33] ? 34'd0 - s1_t_ff[a] : s1_t_ff[a];
         if (absp > {2'b0, s1_h_ff[a]}) in_p = 1'b0;
         if (abst > {3'b0, s1_h_ff[a]}) in_t = 1'b0;
         dnz  = (s1_d_ff[a] != 32'd0);
         dpos = dnz && !s1_d_ff[a][31];
         s2_in.ad[a] = s1_d_ff[a][31] ? 32'd0 - s1_d_ff[a] : s1_d_ff[a];
         hf = {4'b0, s1_h_ff[a]};
         for (int s = 0; s < 2; s++) begin
            face = (s == 0) ? hf : 35'd0 - hf;
            n    = face - {{2{s1_p_ff[a][32]}}, s1_p_ff[a]};
            absn = n[34] ? 35'd0 - n : n;
            s2_in.ns[a][s] = dpos ? n : 35'd0 - n;
            s2_in.ok[a][s] = dnz && !s2_in.ns[a][s][34] && (absn <= {3'b0, s2_in.ad[a]});
         end
      end
      s2_in.in_box = in_p || in_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_p_ff <= s1_p_in;
         s1_t_ff <= s1_t_in;
         s1_h_ff <= s1_h_in;
         s1_d_ff <= s1_d_in;
      end
      if (s2_ready) s2_ff <= s2_in;
   end

endmodule

/* hw/rtl/sbh_prod.sv */
// ----------------------------------------------------------------------------
// Segment box hit test: product stage
// Forms the exact cross-axis products for every face test.
// ----------------------------------------------------------------------------
module sbh_prod (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  sbh_pkg::front_type  in_word,
   output logic                out_valid,
   input  logic                out_stall,
   output sbh_pkg::prod_type   out_word
);
   import sbh_pkg::*;

   logic     valid_ff;
   prod_type word_ff, word_in;
   logic     ready;

   assign ready     = !valid_ff || !out_stall;
   assign in_stall  = !ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      int b;
      word_in.ok     = in_word.ok;
      word_in.in_box = in_word.in_box;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 2; k++) begin
            b = a + k + 1;
            if (b >= 3) b = b - 3;
            word_in.pa[a][k] = 66'($signed(in_word.p[b]) * $signed({1'b0, in_word.ad[a]}));
            word_in.ha[a][k] = 63'(in_word.h[b] * in_word.ad[a]);
            for (int s = 0; s < 2; s++) begin
               word_in.dn[a][s][k] =
                  67'($signed(in_word.d[b]) * $signed(in_word.ns[a][s]));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (ready) word_ff <= word_in;
   end

endmodule

/* hw/rtl/sbh_decide.sv */
// ----------------------------------------------------------------------------
// Segment box hit test: decision stage
// Sums, takes magnitudes, compares and holds the result word.
// ----------------------------------------------------------------------------
module sbh_decide (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  sbh_pkg::prod_type  in_word,
   output logic               out_valid,
   input  logic               out_stall,
   output logic               out_hit
);
   import sbh_pkg::*;

   logic valid_ff;
   logic hit_ff, hit_in;
   logic ready;

   assign ready     = !valid_ff || !out_stall;
   assign in_stall  = !ready;
   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

   always_comb begin
      logic [67:0] lhs, mag;
      logic        face;
      hit_in = in_word.in_box;
      for (int a = 0; a < 3; a++) begin
         for (int s = 0; s < 2; s++) begin
            face = in_word.ok[a][s];
            for (int k = 0; k < 2; k++) begin
               lhs = {{2{in_word.pa[a][k][65]}}, in_word.pa[a][k]}
                   + {in_word.dn[a][s][k][66], in_word.dn[a][s][k]};
               mag = lhs[67] ? 68'd0 - lhs : lhs;
               if (mag > {5'b0, in_word.ha[a][k]}) face = 1'b0;
            end
            if (face) hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (ready) hit_ff <= hit_in;
   end

endmodule

/* hw/rtl/segment_box_hit_test.sv */
// ----------------------------------------------------------------------------
// Segment box hit test
// Tests a configured segment against one axis-aligned box per word.
// ----------------------------------------------------------------------------
//   channel  | direction | ports
//   req      | in        | req_valid, req_stall, req_center_*, req_half_*
//   rsp      | out       | rsp_valid, rsp_stall, rsp_hit
//   csr      | in        | csr_we, csr_index, csr_wdata
//
// Four register stages: end points, face terms, products, decision/output.
// One word enters per cycle while rsp is not stalled; a word's result passes the
// end point, face term, product and decision registers in order before it leaves.
// Each stage advances when empty or when the stage after it moves, so
// bubbles close up and a stalled rsp holds every full stage in place.
// reset (synchronous) empties the pipeline and clears the segment registers.
// Write csr only while no word is in flight.
// ----------------------------------------------------------------------------
`include "segment_box_hit_test_macros.svh"

module segment_box_hit_test #(
   parameter int COORD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [31:0]                      req_center_x,
   input  logic [31:0]                      req_center_y,
   input  logic [31:0]                      req_center_z,
   input  logic [30:0]                      req_half_x,
   input  logic [30:0]                      req_half_y,
   input  logic [30:0]                      req_half_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   input  logic                             csr_we,
   input  logic [sbh_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);
   import sbh_pkg::*;

   logic [2:0][31:0] origin_ff;
   logic [2:0][31:0] dir_ff;

   // Segment registers: drop writes to indexes beyond the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         dir_ff    <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            CSR_DIR_X:    dir_ff[0]    <= csr_wdata;
            CSR_DIR_Y:    dir_ff[1]    <= csr_wdata;
            CSR_DIR_Z:    dir_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic      front_valid, front_stall;
   front_type front_word;
   logic      prod_valid, prod_stall;
   prod_type  prod_word;

   // Stages 1-2: box-relative points, endpoint containment, face ranges.
   sbh_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .origin   (origin_ff),
      .dir      (dir_ff),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .center   ({req_center_z, req_center_y, req_center_x}),
      .half     ({req_half_z, req_half_y, req_half_x}),
      .out_valid(front_valid),
      .out_stall(front_stall),
      .out_word (front_word)
   );

   // Stage 3: exact wide products.
   sbh_prod u_prod (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_stall (front_stall),
      .in_word  (front_word),
      .out_valid(prod_valid),
      .out_stall(prod_stall),
      .out_word (prod_word)
   );

   // Stage 4: compare and hold the result word.
   sbh_decide u_decide (
      .clock    (clock),
      .reset    (reset),
      .in_valid (prod_valid),
      .in_stall (prod_stall),
      .in_word  (prod_word),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_hit  (rsp_hit)
   );

   `SBH_ASSERT_NEXT(a_prod_hold, clock, reset, prod_valid && rsp_valid && rsp_stall, prod_valid, "product word lost under stall")
   `SBH_ASSERT_NEXT(a_front_hold, clock, reset, front_valid && front_stall, front_valid, "front word lost under stall")
   `SBH_ASSERT_SAME(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid, "result valid right after reset")

endmodule
